### src/ttwc_pkg.sv
// ----------------------------------------------------------------------------
// ttwc_pkg
// Shared types and constants of the toroidal tile window cache: field widths,
// the command and result records, the opcode and the back-end state codes.
// ----------------------------------------------------------------------------
package ttwc_pkg;

    localparam int COORD_W  = 20;
    localparam int HANDLE_W = 32;
    localparam int OPC_W    = 2;
    localparam int Q_DEPTH  = 2;

    // Operation codes as they arrive on the opcode port
    typedef enum logic [OPC_W-1:0] {
        OP_MOVE   = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FILL   = 2'd2,
        OP_FORGET = 2'd3
    } t_op;

    // One queued command
    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [HANDLE_W-1:0]        handle;
    } t_cmd;

    // One result transaction
    typedef struct packed {
        logic                       hit;
        logic [HANDLE_W-1:0]        found_handle;
        logic                       moved;
        logic                       fetch_valid;
        logic signed [COORD_W-1:0]  fetch_x;
        logic signed [COORD_W-1:0]  fetch_y;
        logic                       last;
    } t_result;

    // Front to back handshake of the command queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LK_WAIT,
        ST_SWEEP,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

### src/ttwc_ram.sv
// ----------------------------------------------------------------------------
// ttwc_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ttwc_front.sv
// ----------------------------------------------------------------------------
// ttwc_front
// Command front end: decodes the opcode of each accepted transaction and
// holds it in a short queue until the back end takes it.
// ----------------------------------------------------------------------------
module ttwc_front import ttwc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OPC_W-1:0]           i_opcode,
    input  logic signed [COORD_W-1:0]  i_tile_x,
    input  logic signed [COORD_W-1:0]  i_tile_y,
    input  logic [HANDLE_W-1:0]        i_payload_handle,
    output t_q_head                    o_head,
    input  logic                       i_pop
);

    localparam int QAW = $clog2(Q_DEPTH);

    t_cmd             r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QAW:0]     r_count;
    logic [QAW:0]     n_count;
    logic             push;
    t_cmd             cmd_in;

    // Opcode decode: every 2-bit code is a valid operation
    always_comb begin
        cmd_in.x      = i_tile_x;
        cmd_in.y      = i_tile_y;
        cmd_in.handle = i_payload_handle;
        cmd_in.op     = t_op'(i_opcode);
    end

    assign busy = (r_count == (QAW+1)'(Q_DEPTH));
    assign push = start && !busy;

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= (r_wptr == QAW'(Q_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QAW'(Q_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

endmodule

### src/ttwc_back.sv
// ----------------------------------------------------------------------------
// ttwc_back
// Command back end: holds the window state (centre, ring offsets, slot valid
// bits, handle RAM) and carries out move, lookup, fill and forget, emitting
// one result transaction per cycle at most.
// ----------------------------------------------------------------------------
module ttwc_back import ttwc_pkg::*; #(
    parameter int WINDOW_RADIUS = 4,
    parameter int RENDER_RADIUS = 3
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_head  i_head,
    output logic     o_pop,
    output logic     o_strobe,
    output t_result  o_result
);

    localparam int S    = 2*WINDOW_RADIUS + 1;
    localparam int SC   = S*S;
    localparam int RW   = $clog2(S);
    localparam int IW   = $clog2(SC);
    localparam int OW   = RW + 2;
    localparam int RELW = COORD_W + 1;

    localparam logic signed [OW-1:0] SIDE_O = OW'(S);
    localparam logic signed [OW-1:0] RAD_O  = OW'(WINDOW_RADIUS);
    localparam logic signed [OW-1:0] REND_O = OW'(RENDER_RADIUS);

    // Fold a value in (-S, 2S) onto the ring
    function automatic logic [RW-1:0] wrap_side(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] t;
        t = v;
        if (v < 0) begin
            t = v + SIDE_O;
        end else if (v >= SIDE_O) begin
            t = v - SIDE_O;
        end
        return RW'(t);
    endfunction

    // Offset from the centre of the tile held in ring column c
    function automatic logic signed [OW-1:0] off_of(input logic [RW-1:0] c,
                                                   input logic [RW-1:0] ring);
        logic signed [OW-1:0] d;
        d = signed'({2'b00, c}) - signed'({2'b00, ring});
        if (d < 0) begin
            d = d + SIDE_O;
        end
        d = d + RAD_O;
        if (d >= SIDE_O) begin
            d = d - SIDE_O;
        end
        return d - RAD_O;
    endfunction

    t_state                    r_state, n_state;
    t_op                       r_op;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic [HANDLE_W-1:0]       r_handle;
    logic signed [RELW-1:0]    r_rel_x, r_rel_y;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic [RW-1:0]             r_ring_x, r_ring_y;
    logic                      r_pk;
    logic [SC-1:0]             r_valid;
    logic                      r_lk_hit;
    logic signed [OW-1:0]      r_dx, r_dy;
    logic [IW-1:0]             r_idx;
    logic [RW-1:0]             r_sc, r_sr;
    logic signed [OW-1:0]      r_ox, r_oy;
    logic                      r_pend_v;
    logic signed [COORD_W-1:0] r_pend_x, r_pend_y;
    logic                      r_strobe, n_strobe;
    t_result                   r_result, n_result;

    logic                      win_e, same_e, near_e;
    logic [RW-1:0]             col_e, row_e;
    logic [IW-1:0]             slot_e;
    logic                      ram_we;
    logic [HANDLE_W-1:0]       ram_rdata;
    logic signed [OW-1:0]      off_x, off_y, lo_x, hi_x, lo_y, hi_y;
    logic                      keep, sweep_last;
    logic                      win_s, missing, scan_end;
    logic [RW-1:0]             col_s, row_s;
    logic [IW-1:0]             slot_s;
    logic signed [COORD_W-1:0] fx, fy;

    // Classification of the current command against the window
    always_comb begin
        win_e  = r_pk && (r_rel_x >= -WINDOW_RADIUS) && (r_rel_x <= WINDOW_RADIUS) &&
                 (r_rel_y >= -WINDOW_RADIUS) && (r_rel_y <= WINDOW_RADIUS);
        same_e = r_pk && (r_rel_x == '0) && (r_rel_y == '0);
        near_e = r_pk && (r_rel_x > -S) && (r_rel_x < S) && (r_rel_y > -S) && (r_rel_y < S);
        col_e  = wrap_side(OW'(r_rel_x) + signed'({2'b00, r_ring_x}));
        row_e  = wrap_side(OW'(r_rel_y) + signed'({2'b00, r_ring_y}));
        slot_e = IW'(int'(row_e) * S + int'(col_e));
    end

    // Retention test of one slot during a near move
    always_comb begin
        off_x      = off_of(r_sc, r_ring_x);
        off_y      = off_of(r_sr, r_ring_y);
        lo_x       = ((r_dx > 0) ? r_dx : '0) - RAD_O;
        hi_x       = ((r_dx < 0) ? r_dx : '0) + RAD_O;
        lo_y       = ((r_dy > 0) ? r_dy : '0) - RAD_O;
        hi_y       = ((r_dy < 0) ? r_dy : '0) + RAD_O;
        keep       = (off_x >= lo_x) && (off_x <= hi_x) && (off_y >= lo_y) && (off_y <= hi_y);
        sweep_last = (r_idx == IW'(SC-1));
    end

    // Render window scan, one tile a cycle
    always_comb begin
        win_s    = (r_ox >= -RAD_O) && (r_ox <= RAD_O) && (r_oy >= -RAD_O) && (r_oy <= RAD_O);
        col_s    = wrap_side(r_ox + signed'({2'b00, r_ring_x}));
        row_s    = wrap_side(r_oy + signed'({2'b00, r_ring_y}));
        slot_s   = IW'(int'(row_s) * S + int'(col_s));
        missing  = !win_s || !r_valid[slot_s];
        fx       = r_cx + COORD_W'(r_ox);
        fy       = r_cy + COORD_W'(r_oy);
        scan_end = (r_ox == REND_O) && (r_oy == REND_O);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                unique case (r_op)
                    OP_MOVE: begin
                        priority if (same_e) begin
                            n_state = ST_IDLE;
                        end else if (near_e) begin
                            n_state = ST_SWEEP;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                    OP_LOOKUP: n_state = ST_LK_WAIT;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_LK_WAIT: n_state = ST_IDLE;
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop  = (r_state == ST_IDLE) && i_head.valid;
        ram_we = (r_state == ST_EVAL) && (r_op == OP_FILL) && win_e;
    end

    // Handle store
    ttwc_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (SC)
    ) u_handles (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_e),
        .i_wdata (r_handle),
        .i_raddr (slot_e),
        .o_rdata (ram_rdata)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_ring_x <= '0;
            r_ring_y <= '0;
            r_pk     <= 1'b0;
            r_valid  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            unique case (r_state)
                ST_EVAL: begin
                    if (r_op == OP_FILL && win_e) begin
                        r_valid[slot_e] <= 1'b1;
                    end
                    if (r_op == OP_FORGET) begin
                        r_pk <= 1'b0;
                    end
                    if (r_op == OP_MOVE && !same_e) begin
                        r_pend_v <= 1'b0;
                        if (!near_e) begin
                            // Far or first move: start afresh
                            r_valid  <= '0;
                            r_ring_x <= RW'(WINDOW_RADIUS);
                            r_ring_y <= RW'(WINDOW_RADIUS);
                            r_pk     <= 1'b1;
                            r_cx     <= r_x;
                            r_cy     <= r_y;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (!keep) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                    if (sweep_last) begin
                        r_ring_x <= wrap_side(signed'({2'b00, r_ring_x}) + r_dx);
                        r_ring_y <= wrap_side(signed'({2'b00, r_ring_y}) + r_dy);
                        r_cx     <= r_x;
                        r_cy     <= r_y;
                    end
                end
                ST_SCAN: begin
                    if (missing) begin
                        r_pend_v <= 1'b1;
                    end
                end
                ST_FLUSH: r_pend_v <= 1'b0;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op     <= i_head.cmd.op;
                r_x      <= i_head.cmd.x;
                r_y      <= i_head.cmd.y;
                r_handle <= i_head.cmd.handle;
                r_rel_x  <= {i_head.cmd.x[COORD_W-1], i_head.cmd.x} - {r_cx[COORD_W-1], r_cx};
                r_rel_y  <= {i_head.cmd.y[COORD_W-1], i_head.cmd.y} - {r_cy[COORD_W-1], r_cy};
            end
            ST_EVAL: begin
                r_lk_hit <= win_e && r_valid[slot_e];
                r_dx     <= OW'(r_rel_x);
                r_dy     <= OW'(r_rel_y);
                r_idx    <= '0;
                r_sc     <= '0;
                r_sr     <= '0;
                r_ox     <= -REND_O;
                r_oy     <= -REND_O;
            end
            ST_SWEEP: begin
                r_idx <= r_idx + 1'b1;
                if (r_sc == RW'(S-1)) begin
                    r_sc <= '0;
                    r_sr <= r_sr + 1'b1;
                end else begin
                    r_sc <= r_sc + 1'b1;
                end
            end
            ST_SCAN: begin
                if (missing) begin
                    r_pend_x <= fx;
                    r_pend_y <= fy;
                end
                // y inner, x outer
                if (r_oy == REND_O) begin
                    r_oy <= -REND_O;
                    r_ox <= r_ox + 1'b1;
                end else begin
                    r_oy <= r_oy + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result of this cycle
    always_comb begin
        n_strobe = 1'b0;
        n_result = '0;
        unique case (r_state)
            ST_EVAL: begin
                n_strobe      = (r_op != OP_LOOKUP) && !(r_op == OP_MOVE && !same_e);
                n_result.last = 1'b1;
            end
            ST_LK_WAIT: begin
                n_strobe              = 1'b1;
                n_result.hit          = r_lk_hit;
                n_result.found_handle = r_lk_hit ? ram_rdata : '0;
                n_result.last         = 1'b1;
            end
            ST_SCAN: begin
                n_strobe             = missing && r_pend_v;
                n_result.moved       = 1'b1;
                n_result.fetch_valid = 1'b1;
                n_result.fetch_x     = r_pend_x;
                n_result.fetch_y     = r_pend_y;
            end
            ST_FLUSH: begin
                // Last pending fetch, or a move with nothing missing
                n_strobe             = 1'b1;
                n_result.moved       = 1'b1;
                n_result.fetch_valid = r_pend_v;
                n_result.fetch_x     = r_pend_v ? r_pend_x : '0;
                n_result.fetch_y     = r_pend_v ? r_pend_y : '0;
                n_result.last        = 1'b1;
            end
            default: ;
        endcase
    end

    // Result strobe register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### src/toroidal_tile_window_cache_top.sv
// ----------------------------------------------------------------------------
// toroidal_tile_window_cache_top
// Tile window cache around a centre tile, stored as a ring, with move,
// lookup, fill and forget commands and fetch requests for missing tiles.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-entry queue
// stands in front of the engine, so busy rises only when two commands wait.
// Each result is shown for one cycle with o_valid high and must be taken
// then: the receiver cannot hold results off. Lookup gives its result after
// the handle RAM read; fill and forget give theirs straight from evaluation.
// A move to a new centre within reach walks every slot, one a cycle, then
// scans the render window one tile a cycle, emitting one fetch request per
// missing tile, and ends with a flush step that gives the last result; the
// engine takes no other command from the queue until the move is done. A far
// or first move skips the walk; a move to the same centre costs as much as a
// fill.
// ----------------------------------------------------------------------------
module toroidal_tile_window_cache_top import ttwc_pkg::*; #(
    parameter int WINDOW_RADIUS = 4,
    parameter int RENDER_RADIUS = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OPC_W-1:0]           i_opcode,
    input  logic signed [COORD_W-1:0]  i_tile_x,
    input  logic signed [COORD_W-1:0]  i_tile_y,
    input  logic [HANDLE_W-1:0]        i_payload_handle,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic [HANDLE_W-1:0]        o_found_handle,
    output logic                       o_moved,
    output logic                       o_fetch_valid,
    output logic signed [COORD_W-1:0]  o_fetch_x,
    output logic signed [COORD_W-1:0]  o_fetch_y,
    output logic                       o_last
);

    t_q_head head;
    logic    pop;
    t_result result;

    // Command queue
    ttwc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_tile_x         (i_tile_x),
        .i_tile_y         (i_tile_y),
        .i_payload_handle (i_payload_handle),
        .o_head           (head),
        .i_pop            (pop)
    );

    // Window engine
    ttwc_back #(
        .WINDOW_RADIUS (WINDOW_RADIUS),
        .RENDER_RADIUS (RENDER_RADIUS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_valid),
        .o_result (result)
    );

    assign o_hit          = result.hit;
    assign o_found_handle = result.found_handle;
    assign o_moved        = result.moved;
    assign o_fetch_valid  = result.fetch_valid;
    assign o_fetch_x      = result.fetch_x;
    assign o_fetch_y      = result.fetch_y;
    assign o_last         = result.last;

endmodule
